// ----- hw/rtl/usb_control_request_responder_core_macros.svh -----
// ----------------------------------------------------------------------------
// USB control request responder assertion macros
// Shared concurrent assertion wrappers; they compile away under synthesis.
// ----------------------------------------------------------------------------
`ifndef USB_CONTROL_REQUEST_RESPONDER_CORE_MACROS_SVH
`define USB_CONTROL_REQUEST_RESPONDER_CORE_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is asserted.
`define USBCRR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("usbcrr assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define USBCRR_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("usbcrr assertion failed");

`else

`define USBCRR_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define USBCRR_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ----- hw/rtl/usbcrr_pkg.sv -----
// ----------------------------------------------------------------------------
// USB control request responder package
// Request codes, descriptor kinds, sizing constants and the endpoint lookup.
// ----------------------------------------------------------------------------
package usbcrr_pkg;

    // Sizing
    localparam int INTERFACE_COUNT = 3;
    localparam int STRING_COUNT    = 6;
    localparam int HALT_REGISTERS  = 6;

    localparam int IF_IDX_W   = (INTERFACE_COUNT > 1) ? $clog2(INTERFACE_COUNT) : 1;
    localparam int HALT_IDX_W = (HALT_REGISTERS > 1) ? $clog2(HALT_REGISTERS) : 1;

    // Stream widths
    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 56;

    // Configuration registers
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_REMOTE_WAKEUP = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SELF_POWERED  = 1'd1;

    // bmRequestType type field (bits 6..5)
    localparam logic [1:0] TYPE_STANDARD = 2'd0;
    localparam logic [1:0] TYPE_CLASS    = 2'd1;

    // Full bmRequestType values that select a recipient
    localparam logic [7:0] RT_DEVICE_OUT   = 8'h00;
    localparam logic [7:0] RT_ENDPOINT_OUT = 8'h02;
    localparam logic [7:0] RT_DEVICE_IN    = 8'h80;
    localparam logic [7:0] RT_INTERFACE_IN = 8'h81;
    localparam logic [7:0] RT_ENDPOINT_IN  = 8'h82;

    // Standard bRequest codes
    localparam logic [7:0] REQ_GET_STATUS    = 8'h00;
    localparam logic [7:0] REQ_CLEAR_FEATURE = 8'h01;
    localparam logic [7:0] REQ_SET_FEATURE   = 8'h03;
    localparam logic [7:0] REQ_GET_DESC      = 8'h06;
    localparam logic [7:0] REQ_GET_CONFIG    = 8'h08;
    localparam logic [7:0] REQ_SET_CONFIG    = 8'h09;
    localparam logic [7:0] REQ_GET_INTERFACE = 8'h0A;
    localparam logic [7:0] REQ_SET_INTERFACE = 8'h0B;

    // Highest accepted class request code
    localparam logic [7:0] CLASS_OP_MAX = 8'h01;

    // Feature selectors
    localparam logic [7:0] FEAT_ENDPOINT_HALT = 8'd0;
    localparam logic [7:0] FEAT_REMOTE_WAKEUP = 8'd1;

    // Descriptor type codes (wValue high byte)
    localparam logic [7:0] DT_DEVICE      = 8'd1;
    localparam logic [7:0] DT_CONFIG      = 8'd2;
    localparam logic [7:0] DT_STRING      = 8'd3;
    localparam logic [7:0] DT_QUALIFIER   = 8'd6;
    localparam logic [7:0] DT_OTHER_SPEED = 8'd7;

    // Descriptor kinds reported on the result
    localparam logic [2:0] KIND_NONE        = 3'd0;
    localparam logic [2:0] KIND_DEVICE      = 3'd1;
    localparam logic [2:0] KIND_QUALIFIER   = 3'd2;
    localparam logic [2:0] KIND_CONFIG      = 3'd3;
    localparam logic [2:0] KIND_OTHER_SPEED = 3'd4;
    localparam logic [2:0] KIND_STRING      = 3'd5;

    // Bulk max packet sizes
    localparam logic [9:0] PKT_HIGH_SPEED = 10'd512;
    localparam logic [9:0] PKT_FULL_SPEED = 10'd64;

    // Endpoint address lookup
    localparam logic [7:0] EP_ADDR_MASK  = 8'h7E;
    localparam logic [7:0] EP_IN_LIMIT   = 8'd128;
    localparam int         EP_TABLE_LEN  = 10;
    localparam logic [2:0] EP_SLOT [EP_TABLE_LEN] = '{
        3'd0, 3'd1, 3'd2, 3'd2, 3'd3, 3'd3, 3'd4, 3'd4, 3'd5, 3'd5
    };

    typedef struct packed {
        logic                  hit;
        logic [HALT_IDX_W-1:0] slot;
    } t_halt_slot;

    typedef struct packed {
        logic       stall;
        logic [1:0] count;
        logic [7:0] first;
        logic [7:0] second;
        logic [2:0] kind;
        logic [7:0] strn;
        logic [9:0] pkt;
        logic       tog;
        logic [7:0] tog_ep;
    } t_result;

    // Map an endpoint address to its halt register; hit is low outside the table.
    function automatic t_halt_slot halt_slot(input logic [7:0] addr);
        logic [7:0] masked;
        logic [6:0] idx;
        logic [2:0] s;
        t_halt_slot r;
        masked = addr & EP_ADDR_MASK;
        idx    = masked[6:0] | {6'd0, (addr > EP_IN_LIMIT)};
        s      = (idx < 7'(EP_TABLE_LEN)) ? EP_SLOT[idx[3:0]] : 3'd0;
        r.hit  = (idx < 7'(EP_TABLE_LEN)) && (int'(s) < HALT_REGISTERS);
        r.slot = HALT_IDX_W'(s);
        return r;
    endfunction

endpackage

// ----- hw/rtl/usb_control_request_responder_core.sv -----
// ----------------------------------------------------------------------------
// USB control request responder core
// Answers decoded setup packets as a device control endpoint (chapter 9).
// ----------------------------------------------------------------------------
// One setup packet enters per beat on the slave stream and one result beat
// leaves per packet on the master stream, in order. The block sustains one
// packet per clock while the master side takes results: a packet is held in
// the input register, is decoded in a single pass of logic that also reads
// and updates the device state, and lands in the result register, which
// raises result valid. Back-pressure on the master side holds the result
// register; the input register keeps taking a packet while the result
// register drains. Writes to the configuration port take effect at the same
// edge and should be made only while no packet is in flight.
// ----------------------------------------------------------------------------
`include "usb_control_request_responder_core_macros.svh"

module usb_control_request_responder_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Configuration write port
    input  logic                                i_cfg_we,
    input  logic [usbcrr_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [usbcrr_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    // Setup packet stream
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // tdata, low bit up: request_type[7:0], op[15:8], value_low[23:16],
    // value_high[31:24], index_low[39:32], high_speed[40], zero[47:41]
    input  logic [usbcrr_pkg::S_TDATA_W-1:0]    s_axis_tdata,
    // Result stream
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // tdata, low bit up: stall_res[0], reply_count[2:1], reply_first[10:3],
    // reply_second[18:11], descriptor_kind[21:19], string_number[29:22],
    // bulk_packet_size[39:30], toggle_reset[40], toggle_endpoint[48:41],
    // zero[55:49]
    output logic [usbcrr_pkg::M_TDATA_W-1:0]    m_axis_tdata
);
    import usbcrr_pkg::*;

    // Configuration registers
    logic r_wakeup_allowed;
    logic r_self_powered;

    // Device state
    logic [7:0] r_config;
    logic [7:0] r_alt [INTERFACE_COUNT];
    logic       r_wakeup_en;
    logic [HALT_REGISTERS-1:0] r_halted;

    // Input register
    logic       r_in_valid;
    logic [7:0] r_rt;
    logic [7:0] r_op;
    logic [7:0] r_vl;
    logic [7:0] r_vh;
    logic [7:0] r_il;
    logic       r_hs;

    // Result register
    logic    r_out_valid;
    t_result r_out;

    // Handshake
    logic w_out_adv;
    logic w_fire;
    logic w_accept;

    // Decode results and state write intents
    t_result                w_raw;
    t_result                w_res;
    t_halt_slot             w_slot;
    logic [IF_IDX_W-1:0]    w_if_idx;
    logic                   w_if_ok;
    logic                   w_wr_cfg;
    logic                   w_wr_alt;
    logic                   w_wr_wake;
    logic                   w_wake_val;
    logic                   w_wr_halt;
    logic                   w_halt_val;

    // Result register moves when empty or when the sink takes it; the input
    // register moves into it on the same edge.
    assign w_out_adv     = !r_out_valid || m_axis_tready;
    assign w_fire        = r_in_valid && w_out_adv;
    assign s_axis_tready = !r_in_valid || w_out_adv;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    assign w_slot   = halt_slot(r_il);
    assign w_if_ok  = (r_il < 8'(INTERFACE_COUNT));
    assign w_if_idx = r_il[IF_IDX_W-1:0];

    // ------------------------------------------------------------------------
    // Request decode: one pass, reads current state, produces write intents.
    // ------------------------------------------------------------------------
    always_comb begin
        w_raw      = '0;
        w_wr_cfg   = 1'b0;
        w_wr_alt   = 1'b0;
        w_wr_wake  = 1'b0;
        w_wake_val = 1'b0;
        w_wr_halt  = 1'b0;
        w_halt_val = 1'b0;

        unique case (r_rt[6:5])
            TYPE_STANDARD: begin
                unique case (r_op)
                    REQ_GET_DESC: begin
                        unique case (r_vh)
                            DT_DEVICE:    w_raw.kind = KIND_DEVICE;
                            DT_QUALIFIER: w_raw.kind = KIND_QUALIFIER;
                            DT_CONFIG: begin
                                w_raw.kind = KIND_CONFIG;
                                w_raw.pkt  = r_hs ? PKT_HIGH_SPEED : PKT_FULL_SPEED;
                            end
                            DT_OTHER_SPEED: begin
                                // Other-speed config reports the opposite speed's size
                                w_raw.kind = KIND_OTHER_SPEED;
                                w_raw.pkt  = r_hs ? PKT_FULL_SPEED : PKT_HIGH_SPEED;
                            end
                            DT_STRING: begin
                                if (r_vl < 8'(STRING_COUNT)) begin
                                    w_raw.kind = KIND_STRING;
                                    w_raw.strn = r_vl;
                                end else begin
                                    w_raw.stall = 1'b1;
                                end
                            end
                            default: w_raw.stall = 1'b1;
                        endcase
                    end
                    REQ_GET_INTERFACE: begin
                        if (w_if_ok) begin
                            w_raw.count = 2'd1;
                            w_raw.first = r_alt[w_if_idx];
                        end else begin
                            w_raw.stall = 1'b1;
                        end
                    end
                    REQ_SET_INTERFACE: begin
                        if (w_if_ok) begin
                            w_wr_alt = 1'b1;
                        end else begin
                            w_raw.stall = 1'b1;
                        end
                    end
                    REQ_SET_CONFIG: begin
                        w_wr_cfg = 1'b1;
                    end
                    REQ_GET_CONFIG: begin
                        w_raw.count = 2'd1;
                        w_raw.first = r_config;
                    end
                    REQ_GET_STATUS: begin
                        priority if (r_rt == RT_DEVICE_IN) begin
                            w_raw.count = 2'd2;
                            w_raw.first = {6'd0, r_wakeup_en, r_self_powered};
                        end else if (r_rt == RT_INTERFACE_IN) begin
                            w_raw.count = 2'd2;
                        end else if (r_rt == RT_ENDPOINT_IN) begin
                            w_raw.count = 2'd2;
                            if (w_slot.hit) begin
                                w_raw.first = {7'd0, r_halted[w_slot.slot]};
                            end
                        end else begin
                            w_raw.stall = 1'b1;
                        end
                    end
                    REQ_CLEAR_FEATURE: begin
                        priority if (r_rt == RT_DEVICE_OUT) begin
                            if (r_vl == FEAT_REMOTE_WAKEUP) begin
                                w_wr_wake  = 1'b1;
                                w_wake_val = 1'b0;
                            end else begin
                                w_raw.stall = 1'b1;
                            end
                        end else if (r_rt == RT_ENDPOINT_OUT) begin
                            if (r_vl == FEAT_ENDPOINT_HALT) begin
                                // Unknown endpoints still get their toggle reset
                                w_wr_halt    = w_slot.hit;
                                w_halt_val   = 1'b0;
                                w_raw.tog    = 1'b1;
                                w_raw.tog_ep = r_il;
                            end else begin
                                w_raw.stall = 1'b1;
                            end
                        end else begin
                            w_raw.stall = 1'b1;
                        end
                    end
                    REQ_SET_FEATURE: begin
                        priority if (r_rt == RT_DEVICE_OUT) begin
                            if ((r_vl == FEAT_REMOTE_WAKEUP) && r_wakeup_allowed) begin
                                w_wr_wake  = 1'b1;
                                w_wake_val = 1'b1;
                            end else begin
                                w_raw.stall = 1'b1;
                            end
                        end else if (r_rt == RT_ENDPOINT_OUT) begin
                            if (r_vl == FEAT_ENDPOINT_HALT) begin
                                w_wr_halt  = w_slot.hit;
                                w_halt_val = 1'b1;
                            end else begin
                                w_raw.stall = 1'b1;
                            end
                        end else begin
                            w_raw.stall = 1'b1;
                        end
                    end
                    default: w_raw.stall = 1'b1;
                endcase
            end
            TYPE_CLASS: begin
                // Class requests 0 and 1 complete with no data
                if (r_op > CLASS_OP_MAX) begin
                    w_raw.stall = 1'b1;
                end
            end
            default: w_raw.stall = 1'b1;
        endcase

        // A stalled request carries nothing else
        if (w_raw.stall) begin
            w_res       = '0;
            w_res.stall = 1'b1;
        end else begin
            w_res = w_raw;
        end
    end

    // ------------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wakeup_allowed <= 1'b0;
            r_self_powered   <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_REMOTE_WAKEUP: r_wakeup_allowed <= i_cfg_data[0];
                CFG_SELF_POWERED:  r_self_powered   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Device state: update only as a packet leaves the input register, so the
    // next packet sees the result of this one.
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_config    <= '0;
            r_wakeup_en <= 1'b0;
            r_halted    <= '0;
            for (int i = 0; i < INTERFACE_COUNT; i++) begin
                r_alt[i] <= '0;
            end
        end else if (w_fire && !w_res.stall) begin
            if (w_wr_cfg) begin
                r_config <= r_vl;
            end
            if (w_wr_alt) begin
                r_alt[w_if_idx] <= r_vl;
            end
            if (w_wr_wake) begin
                r_wakeup_en <= w_wake_val;
            end
            if (w_wr_halt) begin
                r_halted[w_slot.slot] <= w_halt_val;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Input register: capture a packet whenever the slot is free or draining.
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_rt <= s_axis_tdata[7:0];
            r_op <= s_axis_tdata[15:8];
            r_vl <= s_axis_tdata[23:16];
            r_vh <= s_axis_tdata[31:24];
            r_il <= s_axis_tdata[39:32];
            r_hs <= s_axis_tdata[40];
        end
    end

    // ------------------------------------------------------------------------
    // Result register: hold while the sink stalls.
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_adv) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out <= w_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'd0, r_out.tog_ep, r_out.tog, r_out.pkt, r_out.strn,
                            r_out.kind, r_out.second, r_out.first, r_out.count,
                            r_out.stall};

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    `USBCRR_ASSERT_IMP(a_stall_clears_fields, i_clk, i_rst_n,
        r_out_valid && r_out.stall,
        r_out.count == 2'd0 && r_out.first == 8'd0 && r_out.kind == KIND_NONE && !r_out.tog)
    `USBCRR_ASSERT_IMP(a_toggle_no_reply, i_clk, i_rst_n,
        r_out_valid && r_out.tog,
        r_out.count == 2'd0 && r_out.kind == KIND_NONE && r_out.pkt == 10'd0)
    `USBCRR_ASSERT_IMP(a_pkt_only_config, i_clk, i_rst_n,
        r_out_valid && r_out.pkt != 10'd0,
        r_out.kind == KIND_CONFIG || r_out.kind == KIND_OTHER_SPEED)
    `USBCRR_ASSERT_NXT(a_set_config_stored, i_clk, i_rst_n,
        w_fire && w_wr_cfg,
        r_config == $past(r_vl))
    `USBCRR_ASSERT_NXT(a_input_held_on_stall, i_clk, i_rst_n,
        r_in_valid && r_out_valid && !m_axis_tready,
        r_in_valid && $stable(r_op) && $stable(r_rt))

endmodule

// ----- tb/request_reply_monitor.sv -----
// ----------------------------------------------------------------------------
// Control request reply monitor
// Watches the setup and reply streams and the register port of the control
// request responder, predicts each reply from its own copy of the device
// state and checks every reply beat field by field, in order.
// ----------------------------------------------------------------------------
module request_reply_monitor (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [usbcrr_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [usbcrr_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                               i_setup_valid,
    input  logic                               i_setup_ready,
    input  logic [usbcrr_pkg::S_TDATA_W-1:0]   i_setup_data,
    input  logic                               i_reply_valid,
    input  logic                               i_reply_ready,
    input  logic [usbcrr_pkg::M_TDATA_W-1:0]   i_reply_data,
    output int                                 o_errors,
    output int                                 o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import usbcrr_pkg::*;

    // Device state as the host sees it
    logic       wakeup_allowed;
    logic       self_powered;
    logic [7:0] config_value;
    logic [7:0] alt_setting [INTERFACE_COUNT];
    logic       wakeup_enabled;
    logic       halted [HALT_REGISTERS];

    t_result expected_replies [$];
    int      err_count = 0;

    // Halt register of an endpoint address, -1 outside the lookup table.
    function automatic int halt_index(input logic [7:0] addr);
        int idx;
        int slot;
        idx = int'(addr & EP_ADDR_MASK) | int'(addr > EP_IN_LIMIT);
        if (idx >= EP_TABLE_LEN)
            return -1;
        slot = (idx < 2) ? idx : (idx / 2) + 1;
        return (slot < HALT_REGISTERS) ? slot : -1;
    endfunction

    // Answer one setup packet and update the device state it touches.
    function automatic t_result answer_request(input logic [S_TDATA_W-1:0] beat);
        t_result    r;
        logic [7:0] rt;
        logic [7:0] op;
        logic [7:0] vl;
        logic [7:0] vh;
        logic [7:0] il;
        logic       hs;
        logic       refuse;
        int         slot;
        r      = '0;
        refuse = 1'b0;
        rt     = beat[7:0];
        op     = beat[15:8];
        vl     = beat[23:16];
        vh     = beat[31:24];
        il     = beat[39:32];
        hs     = beat[40];
        case (rt[6:5])
            TYPE_STANDARD: begin
                case (op)
                    REQ_GET_DESC: begin
                        case (vh)
                            DT_DEVICE:    r.kind = KIND_DEVICE;
                            DT_QUALIFIER: r.kind = KIND_QUALIFIER;
                            DT_CONFIG: begin
                                r.kind = KIND_CONFIG;
                                r.pkt  = hs ? PKT_HIGH_SPEED : PKT_FULL_SPEED;
                            end
                            DT_OTHER_SPEED: begin
                                r.kind = KIND_OTHER_SPEED;
                                r.pkt  = hs ? PKT_FULL_SPEED : PKT_HIGH_SPEED;
                            end
                            DT_STRING: begin
                                if (int'(vl) >= STRING_COUNT) begin
                                    refuse = 1'b1;
                                end else begin
                                    r.kind = KIND_STRING;
                                    r.strn = vl;
                                end
                            end
                            default: refuse = 1'b1;
                        endcase
                    end
                    REQ_GET_INTERFACE: begin
                        if (int'(il) < INTERFACE_COUNT) begin
                            r.count = 2'd1;
                            r.first = alt_setting[int'(il)];
                        end else begin
                            refuse = 1'b1;
                        end
                    end
                    REQ_SET_INTERFACE: begin
                        if (int'(il) < INTERFACE_COUNT)
                            alt_setting[int'(il)] = vl;
                        else
                            refuse = 1'b1;
                    end
                    REQ_SET_CONFIG: config_value = vl;
                    REQ_GET_CONFIG: begin
                        r.count = 2'd1;
                        r.first = config_value;
                    end
                    REQ_GET_STATUS: begin
                        if (rt == RT_DEVICE_IN) begin
                            r.count = 2'd2;
                            r.first = {6'd0, wakeup_enabled, self_powered};
                        end else if (rt == RT_INTERFACE_IN) begin
                            r.count = 2'd2;
                        end else if (rt == RT_ENDPOINT_IN) begin
                            r.count = 2'd2;
                            slot    = halt_index(il);
                            if (slot >= 0)
                                r.first = {7'd0, halted[slot]};
                        end else begin
                            refuse = 1'b1;
                        end
                    end
                    REQ_CLEAR_FEATURE: begin
                        if (rt == RT_DEVICE_OUT && vl == FEAT_REMOTE_WAKEUP) begin
                            wakeup_enabled = 1'b0;
                        end else if (rt == RT_ENDPOINT_OUT && vl == FEAT_ENDPOINT_HALT) begin
                            slot = halt_index(il);
                            if (slot >= 0)
                                halted[slot] = 1'b0;
                            r.tog    = 1'b1;
                            r.tog_ep = il;
                        end else begin
                            refuse = 1'b1;
                        end
                    end
                    REQ_SET_FEATURE: begin
                        if (rt == RT_DEVICE_OUT && vl == FEAT_REMOTE_WAKEUP && wakeup_allowed) begin
                            wakeup_enabled = 1'b1;
                        end else if (rt == RT_ENDPOINT_OUT && vl == FEAT_ENDPOINT_HALT) begin
                            slot = halt_index(il);
                            if (slot >= 0)
                                halted[slot] = 1'b1;
                        end else begin
                            refuse = 1'b1;
                        end
                    end
                    default: refuse = 1'b1;
                endcase
            end
            TYPE_CLASS: refuse = (op > CLASS_OP_MAX);
            default:    refuse = 1'b1;
        endcase
        if (refuse) begin
            r       = '0;
            r.stall = 1'b1;
        end
        return r;
    endfunction

    function automatic t_result unpack_reply(input logic [M_TDATA_W-1:0] beat);
        t_result r;
        r.stall  = beat[0];
        r.count  = beat[2:1];
        r.first  = beat[10:3];
        r.second = beat[18:11];
        r.kind   = beat[21:19];
        r.strn   = beat[29:22];
        r.pkt    = beat[39:30];
        r.tog    = beat[40];
        r.tog_ep = beat[48:41];
        return r;
    endfunction

    task automatic check_field(input string name, input logic [9:0] want, input logic [9:0] got);
        if (got !== want) begin
            err_count++;
            $display("%0t: reply %s mismatch, expected %0h, got %0h", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_result want;
        t_result seen;
        if (!i_rst_n) begin
            wakeup_allowed = 1'b0;
            self_powered   = 1'b0;
            config_value   = '0;
            wakeup_enabled = 1'b0;
            foreach (alt_setting[k]) alt_setting[k] = '0;
            foreach (halted[k]) halted[k] = 1'b0;
            expected_replies.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_REMOTE_WAKEUP: wakeup_allowed = i_cfg_data[0];
                    CFG_SELF_POWERED:  self_powered   = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_reply_valid && i_reply_ready) begin
                if (expected_replies.size() == 0) begin
                    err_count++;
                    $display("%0t: reply beat with none expected, expected none, got %0h",
                             $time, i_reply_data);
                end else begin
                    want = expected_replies.pop_front();
                    seen = unpack_reply(i_reply_data);
                    check_field("stall", 10'(want.stall), 10'(seen.stall));
                    check_field("count", 10'(want.count), 10'(seen.count));
                    check_field("first", 10'(want.first), 10'(seen.first));
                    check_field("second", 10'(want.second), 10'(seen.second));
                    check_field("kind", 10'(want.kind), 10'(seen.kind));
                    check_field("string", 10'(want.strn), 10'(seen.strn));
                    check_field("packet size", want.pkt, seen.pkt);
                    check_field("toggle", 10'(want.tog), 10'(seen.tog));
                    check_field("toggle ep", 10'(want.tog_ep), 10'(seen.tog_ep));
                    check_field("pad", '0, 10'(i_reply_data[M_TDATA_W-1:49]));
                end
            end
            if (i_setup_valid && i_setup_ready)
                expected_replies.push_back(answer_request(i_setup_data));
        end
        o_errors  <= err_count;
        o_pending <= expected_replies.size();
    end

endmodule

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// Control request responder testbench
// Drives setup packets into the responder with random gaps on both streams,
// walks the remote-wakeup and self-powered settings between phases and lets
// the reply monitor predict and check every reply beat.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import usbcrr_pkg::*;

    // Request types the package does not name
    localparam logic [7:0] RT_INTERFACE_OUT = 8'h01;
    localparam logic [7:0] RT_CLASS_OUT     = {1'b0, TYPE_CLASS, 5'd1};
    localparam logic [7:0] RT_VENDOR_OUT    = 8'h40;
    // Keep direction and recipient, force the standard type field
    localparam logic [7:0] STD_TYPE_MASK    = 8'h9F;

    localparam int PHASES         = 4;
    localparam int PHASE_ITEMS    = 500;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 3000;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    logic [S_TDATA_W-1:0]  s_data    = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    logic [M_TDATA_W-1:0]  m_data;

    int errors;
    int pending;
    int stuck     = 0;
    bit quiet     = 1'b0;   // no idling on either side
    bit hold_req  = 1'b0;   // ask the receiver for one long hold-off

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    usb_control_request_responder_core DUT (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .s_axis_tvalid (s_valid),
        .s_axis_tready (s_ready),
        .s_axis_tdata  (s_data),
        .m_axis_tvalid (m_valid),
        .m_axis_tready (m_ready),
        .m_axis_tdata  (m_data)
    );

    request_reply_monitor monitor (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .i_setup_valid (s_valid),
        .i_setup_ready (s_ready),
        .i_setup_data  (s_data),
        .i_reply_valid (m_valid),
        .i_reply_ready (m_ready),
        .i_reply_data  (m_data),
        .o_errors      (errors),
        .o_pending     (pending)
    );

    // Idle length for either side: mostly none or short, now and then long.
    function automatic int idle_gap();
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Pack one setup beat, request_type in the lowest byte.
    function automatic logic [S_TDATA_W-1:0] make_setup(input logic [7:0] rt,
                                                        input logic [7:0] op,
                                                        input logic [7:0] vl,
                                                        input logic [7:0] vh,
                                                        input logic [7:0] il,
                                                        input logic       hs);
        return {7'd0, hs, il, vh, vl, op, rt};
    endfunction

    // Endpoint address: mostly inside or just past the halt lookup table.
    function automatic logic [7:0] pick_endpoint();
        logic [7:0] a;
        a = 8'($urandom);
        if ($urandom_range(0, 3) != 0)
            a = {1'($urandom_range(0, 1)), 7'($urandom_range(0, 11))};
        return a;
    endfunction

    function automatic logic [7:0] pick_interface();
        logic [7:0] n;
        n = 8'($urandom);
        if ($urandom_range(0, 3) != 0)
            n = 8'($urandom_range(0, INTERFACE_COUNT));
        return n;
    endfunction

    function automatic logic [7:0] pick_feature();
        logic [7:0] f;
        f = 8'($urandom);
        if ($urandom_range(0, 3) != 0)
            f = $urandom_range(0, 1) ? FEAT_REMOTE_WAKEUP : FEAT_ENDPOINT_HALT;
        return f;
    endfunction

    // Random setup packet: mostly well-formed requests with random content,
    // the rest reserved types, unknown codes and plain noise.
    function automatic logic [S_TDATA_W-1:0] random_setup();
        logic [7:0] rt;
        logic [7:0] op;
        logic [7:0] vl;
        logic [7:0] vh;
        logic [7:0] il;
        logic       hs;
        int         pick;
        rt   = 8'($urandom);
        rt   = rt & STD_TYPE_MASK;
        op   = 8'($urandom);
        vl   = 8'($urandom);
        vh   = 8'($urandom);
        il   = 8'($urandom);
        hs   = 1'($urandom_range(0, 1));
        pick = $urandom_range(0, 15);
        case (pick)
            0: rt = 8'($urandom);
            1, 2: begin
                op = REQ_GET_DESC;
                case ($urandom_range(0, 5))
                    0: vh = DT_DEVICE;
                    1: vh = DT_CONFIG;
                    2: vh = DT_STRING;
                    3: vh = DT_QUALIFIER;
                    4: vh = DT_OTHER_SPEED;
                    default: ;
                endcase
                if ($urandom_range(0, 3) != 0)
                    vl = 8'($urandom_range(0, STRING_COUNT + 1));
            end
            3: begin
                rt = RT_INTERFACE_IN;
                op = REQ_GET_INTERFACE;
                il = pick_interface();
            end
            4: begin
                op = REQ_SET_INTERFACE;
                il = pick_interface();
            end
            5: op = REQ_SET_CONFIG;
            6: begin
                rt = RT_DEVICE_IN;
                op = REQ_GET_CONFIG;
            end
            7, 8: begin
                op = REQ_GET_STATUS;
                case ($urandom_range(0, 4))
                    0: rt = RT_DEVICE_IN;
                    1: rt = RT_INTERFACE_IN;
                    2, 3: begin
                        rt = RT_ENDPOINT_IN;
                        il = pick_endpoint();
                    end
                    default: ;
                endcase
            end
            9, 10, 11, 12: begin
                op = (pick < 11) ? REQ_CLEAR_FEATURE : REQ_SET_FEATURE;
                vl = pick_feature();
                case ($urandom_range(0, 4))
                    0: rt = RT_DEVICE_OUT;
                    1, 2, 3: begin
                        rt = RT_ENDPOINT_OUT;
                        il = pick_endpoint();
                    end
                    default: ;
                endcase
            end
            13: begin
                rt = rt | {1'b0, TYPE_CLASS, 5'd0};
                if ($urandom_range(0, 1))
                    op = 8'($urandom_range(0, 3));
            end
            14: rt[6] = 1'b1;   // vendor or reserved type
            default: ;          // unknown standard codes mostly
        endcase
        return make_setup(rt, op, vl, vh, il, hs);
    endfunction

    // Offer one setup beat; return at the edge that accepts it. Valid stays
    // high when no gap follows, so back-to-back beats never drop it.
    task automatic send_setup(input logic [S_TDATA_W-1:0] beat);
        int gap;
        gap = hold_req ? 0 : idle_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_valid <= 1'b1;
        s_data  <= beat;
        @(posedge clk);
        while (!s_ready) @(posedge clk);
    endtask

    // Drop valid and wait until every reply has come back. The first edge
    // lets the monitor count the beat accepted at the current edge.
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    // One register write; return once the write enable has dropped and been sampled low.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    // Receiver: random ready with short and long stalls, plus one long
    // hold-off on request so the input side backs up and stalls.
    initial begin : reply_sink
        int gap;
        int run;
        @(posedge clk);
        forever begin
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end else begin
                gap = idle_gap();
                if (gap > 0) begin
                    m_ready <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
                m_ready <= 1'b1;
                run = $urandom_range(1, 8);
                repeat (run) @(posedge clk);
            end
        end
    end

    // Watchdog: end the run when nothing moves on either stream for too long.
    always @(posedge clk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            stuck <= 0;
        else
            stuck <= stuck + 1;
        if (stuck >= WATCHDOG_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin : setup_source
        logic wake_cfg [PHASES];
        logic pwr_cfg [PHASES];
        wake_cfg = '{1'b1, 1'b0, 1'b1, 1'b1};
        pwr_cfg  = '{1'b1, 1'b1, 1'b0, 1'b1};

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed pass with both settings at their reset value
        send_setup(make_setup(RT_DEVICE_IN, REQ_GET_STATUS, 8'h00, 8'h00, 8'h00, 1'b0));
        send_setup(make_setup(RT_DEVICE_IN, REQ_GET_DESC, 8'h00, DT_DEVICE, 8'h00, 1'b0));
        send_setup(make_setup(RT_DEVICE_IN, REQ_GET_DESC, 8'hFF, DT_QUALIFIER, 8'hFF, 1'b1));
        send_setup(make_setup(RT_DEVICE_IN, REQ_GET_DESC, 8'hFF, DT_CONFIG, 8'hFF, 1'b1));
        send_setup(make_setup(RT_DEVICE_IN, REQ_GET_DESC, 8'h00, DT_CONFIG, 8'h00, 1'b0));
        send_setup(make_setup(RT_DEVICE_IN, REQ_GET_DESC, 8'h00, DT_OTHER_SPEED, 8'h00, 1'b1));
        send_setup(make_setup(RT_DEVICE_IN, REQ_GET_DESC, 8'h00, DT_OTHER_SPEED, 8'h00, 1'b0));
        // Last valid string index, then the first one past the end
        send_setup(make_setup(RT_DEVICE_IN, REQ_GET_DESC, 8'(STRING_COUNT - 1), DT_STRING,
                              8'h00, 1'b0));
        send_setup(make_setup(RT_DEVICE_IN, REQ_GET_DESC, 8'(STRING_COUNT), DT_STRING,
                              8'h00, 1'b0));
        send_setup(make_setup(RT_DEVICE_IN, REQ_GET_DESC, 8'h00, 8'hFF, 8'h00, 1'b0));
        // Highest interface holds an all-ones setting; one past it stalls
        send_setup(make_setup(RT_INTERFACE_OUT, REQ_SET_INTERFACE, 8'hFF, 8'h00,
                              8'(INTERFACE_COUNT - 1), 1'b0));
        send_setup(make_setup(RT_INTERFACE_IN, REQ_GET_INTERFACE, 8'h00, 8'h00,
                              8'(INTERFACE_COUNT - 1), 1'b0));
        send_setup(make_setup(RT_INTERFACE_IN, REQ_GET_INTERFACE, 8'h00, 8'h00,
                              8'(INTERFACE_COUNT), 1'b0));
        send_setup(make_setup(RT_DEVICE_OUT, REQ_SET_CONFIG, 8'hFF, 8'h00, 8'h00, 1'b0));
        send_setup(make_setup(RT_DEVICE_IN, REQ_GET_CONFIG, 8'h00, 8'h00, 8'h00, 1'b0));
        // Remote wakeup not allowed yet: must stall
        send_setup(make_setup(RT_DEVICE_OUT, REQ_SET_FEATURE, FEAT_REMOTE_WAKEUP, 8'h00,
                              8'h00, 1'b0));
        // Halt an IN endpoint, read it back, clear it
        send_setup(make_setup(RT_ENDPOINT_OUT, REQ_SET_FEATURE, FEAT_ENDPOINT_HALT, 8'h00,
                              8'h81, 1'b0));
        send_setup(make_setup(RT_ENDPOINT_IN, REQ_GET_STATUS, 8'h00, 8'h00, 8'h81, 1'b0));
        send_setup(make_setup(RT_ENDPOINT_OUT, REQ_CLEAR_FEATURE, FEAT_ENDPOINT_HALT, 8'h00,
                              8'h81, 1'b0));
        // Endpoint outside the table: toggle reset still raised, status reads zero
        send_setup(make_setup(RT_ENDPOINT_OUT, REQ_CLEAR_FEATURE, FEAT_ENDPOINT_HALT, 8'h00,
                              8'hFF, 1'b0));
        send_setup(make_setup(RT_ENDPOINT_IN, REQ_GET_STATUS, 8'h00, 8'h00, 8'hFF, 1'b0));
        send_setup(make_setup(RT_INTERFACE_IN, REQ_GET_STATUS, 8'h00, 8'h00, 8'h00, 1'b0));
        // Feature aimed at an interface stalls
        send_setup(make_setup(RT_INTERFACE_OUT, REQ_CLEAR_FEATURE, FEAT_ENDPOINT_HALT, 8'h00,
                              8'h00, 1'b0));
        // Class requests: highest accepted code, then the next one
        send_setup(make_setup(RT_CLASS_OUT, CLASS_OP_MAX, 8'h00, 8'h00, 8'h00, 1'b0));
        send_setup(make_setup(RT_CLASS_OUT, CLASS_OP_MAX + 8'd1, 8'h00, 8'h00, 8'h00, 1'b0));
        send_setup(make_setup(RT_VENDOR_OUT, REQ_GET_STATUS, 8'h00, 8'h00, 8'h00, 1'b0));
        send_setup(make_setup(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1));

        // Allow remote wakeup and walk the device feature through it
        drain();
        write_reg(CFG_REMOTE_WAKEUP, 1'b1);
        send_setup(make_setup(RT_DEVICE_OUT, REQ_SET_FEATURE, FEAT_REMOTE_WAKEUP, 8'h00,
                              8'h00, 1'b0));
        send_setup(make_setup(RT_DEVICE_IN, REQ_GET_STATUS, 8'h00, 8'h00, 8'h00, 1'b0));
        send_setup(make_setup(RT_DEVICE_OUT, REQ_CLEAR_FEATURE, FEAT_REMOTE_WAKEUP, 8'h00,
                              8'h00, 1'b0));
        send_setup(make_setup(RT_DEVICE_OUT, REQ_SET_FEATURE, FEAT_ENDPOINT_HALT, 8'h00,
                              8'h00, 1'b0));

        // Random phases, one register setting each; the third runs without
        // idling, the first carries the long receiver hold-off.
        for (int ph = 0; ph < PHASES; ph++) begin
            drain();
            write_reg(CFG_REMOTE_WAKEUP, wake_cfg[ph]);
            write_reg(CFG_SELF_POWERED, pwr_cfg[ph]);
            quiet = (ph == 2);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (ph == 0 && n == 100)
                    hold_req = 1'b1;
                send_setup(random_setup());
            end
        end
        quiet = 1'b0;

        drain();
        repeat (10) @(posedge clk);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+hw/rtl
hw/rtl/usbcrr_pkg.sv
hw/rtl/usb_control_request_responder_core.sv
tb/request_reply_monitor.sv
tb/testbench.sv
